// File: src/gcpd_pkg.sv
// shared constants, types and pattern table of the gray corner pattern detector
package gcpd_pkg;

  // default frame limits and queue size
  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 2048;
  localparam int unsigned QUEUE_DEPTH    = 4;

  // field widths
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned THRESH_W    = 8;
  localparam int unsigned DIM_W       = 12;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 12;

  // frame size after reset
  localparam logic [DIM_W-1:0] DIM_RESET = 12'd2048;

  // output level on a match
  localparam logic [PIX_W-1:0] CORNER_ON = 8'hFF;

  // item kinds
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  // register indexes of the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } reg_idx_e;

  // classified item handed from front to back
  typedef struct packed {
    logic             is_pix;  // shifts the window and updates the line store
    logic             emit;    // produces a result
    logic             zero;    // border pixel or drained pixel, result forced to zero
    logic             last;    // final result of the frame
    logic [PIX_W-1:0] pix;
  } item_t;

  // ring codes that count as a corner
  localparam logic [7:0] RING_PATTERNS [16] = '{
    8'hE0, 8'h70, 8'h38, 8'h1C, 8'h0E, 8'h07, 8'h83, 8'hC1,
    8'hA0, 8'h50, 8'h28, 8'h14, 8'h0A, 8'h05, 8'h82, 8'h41
  };

  // window position of each ring bit: left first, then clockwise
  localparam int unsigned RING_TAP [8] = '{3, 0, 1, 2, 5, 8, 7, 6};

  // true when the ring code is one of the corner patterns
  function automatic logic ring_match(input logic [7:0] code);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (code == RING_PATTERNS[i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// File: src/gcpd_if.sv
// channel interfaces: pixel input, result output and configuration writes

interface gcpd_pix_if;
  logic                           valid;
  logic                           ready;
  gcpd_pkg::op_e                  opcode;
  logic [gcpd_pkg::PIX_W-1:0]     pixel_value;

  modport source (output valid, opcode, pixel_value, input ready);
  modport sink   (input valid, opcode, pixel_value, output ready);
endinterface

interface gcpd_res_if;
  logic                           valid;
  logic                           ready;
  logic                           valid_res;
  logic [gcpd_pkg::PIX_W-1:0]     corner_value;
  logic                           last_of_frame;

  modport source (output valid, valid_res, corner_value, last_of_frame, input ready);
  modport sink   (input valid, valid_res, corner_value, last_of_frame, output ready);
endinterface

interface gcpd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [gcpd_pkg::CFG_INDEX_W-1:0]   index;
  logic [gcpd_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/gray_corner_pattern_detect.sv
// top level of the gray corner pattern detector
//
//   channel  dir  handshake          payload
//   pix_i    in   valid/ready        opcode, pixel_value
//   res_o    out  valid/ready        valid_res, corner_value, last_of_frame
//   cfg_i    in   valid/ready (=1)   index, data
//
// one item per cycle while ready; a result then passes the queue, r, w and output registers.
// the line store is one memory port pair: one read and one write of a row entry per cycle.
// after reset and after every register write, the steps ST_MUL_P, ST_MUL_Q and ST_MUL_T rebuild
// the linear frame indexes on a shared multiplier, pix_i.ready stays low meanwhile.
// a stalled result freezes the back end; a 4-entry queue keeps the front accepting
// until it fills.
module gray_corner_pattern_detect #(
  parameter int unsigned MAX_WIDTH  = gcpd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = gcpd_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gcpd_pix_if.sink    pix_i,
  gcpd_res_if.source  res_o,
  gcpd_cfg_if.sink    cfg_i
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);

  logic [gcpd_pkg::THRESH_W-1:0]  threshold;
  logic                           push;
  gcpd_pkg::item_t                push_item;
  logic [XW-1:0]                  push_x;
  logic                           full;
  logic                           pop;
  logic                           q_valid;
  gcpd_pkg::item_t                q_item;
  logic [XW-1:0]                  q_x;

  // classification and raster bookkeeping
  gcpd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_i),
    .cfg_i       (cfg_i),
    .threshold_o (threshold),
    .full_i      (full),
    .push_o      (push),
    .item_o      (push_item),
    .x_o         (push_x)
  );

  // decoupling queue
  gcpd_queue #(
    .DEPTH (gcpd_pkg::QUEUE_DEPTH),
    .XW    (XW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .push_x_i    (push_x),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .item_o      (q_item),
    .x_o         (q_x)
  );

  // window and corner test
  gcpd_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .threshold_i (threshold),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_x_i       (q_x),
    .q_pop_o     (pop),
    .res_o       (res_o)
  );

endmodule

// File: src/gcpd_queue.sv
// short item queue between the classifying front and the window back
module gcpd_queue #(
  parameter int unsigned DEPTH = gcpd_pkg::QUEUE_DEPTH,
  parameter int unsigned XW    = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gcpd_pkg::item_t push_item_i,
  input  logic [XW-1:0]   push_x_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output gcpd_pkg::item_t item_o,
  output logic [XW-1:0]   x_o
);

  localparam int unsigned PW   = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  gcpd_pkg::item_t item_mem [DEPTH];
  logic [XW-1:0]   x_mem    [DEPTH];

  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] count_q, count_d;

  // status
  assign full_o  = (count_q == CNTW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = item_mem[rd_ptr_q];
  assign x_o     = x_mem[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    priority if (push_i && !pop_i) begin
      count_d = count_q + CNTW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNTW'(1);
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_mem[wr_ptr_q] <= push_item_i;
      x_mem[wr_ptr_q]    <= push_x_i;
    end
  end

endmodule

// File: src/gcpd_front.sv
// front end: configuration, raster counters, result decision and item classification
module gcpd_front #(
  parameter int unsigned MAX_WIDTH  = gcpd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = gcpd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  gcpd_pix_if.sink                        pix_i,
  gcpd_cfg_if.sink                        cfg_i,
  output logic [gcpd_pkg::THRESH_W-1:0]   threshold_o,
  input  logic                            full_i,
  output logic                            push_o,
  output gcpd_pkg::item_t                 item_o,
  output logic [$clog2(MAX_WIDTH)-1:0]    x_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
  localparam int unsigned MW = HW + WW;
  localparam int unsigned SW = (LW > gcpd_pkg::DIM_W) ? LW : gcpd_pkg::DIM_W;

  // run state and the three product steps that rebuild the linear indexes
  typedef enum logic [3:0] {
    ST_RUN   = 4'b0001,
    ST_MUL_P = 4'b0010,
    ST_MUL_Q = 4'b0100,
    ST_MUL_T = 4'b1000
  } fe_state_e;

  function automatic logic [WW-1:0] sat_width(input logic [gcpd_pkg::DIM_W-1:0] v);
    logic [WW-1:0] r;
    if (v == '0) begin
      r = WW'(1);
    end else if (SW'(v) > SW'(MAX_WIDTH)) begin
      r = WW'(MAX_WIDTH);
    end else begin
      r = WW'(v);
    end
    return r;
  endfunction

  function automatic logic [HW-1:0] sat_height(input logic [gcpd_pkg::DIM_W-1:0] v);
    logic [HW-1:0] r;
    if (v == '0) begin
      r = HW'(1);
    end else if (SW'(v) > SW'(MAX_HEIGHT)) begin
      r = HW'(MAX_HEIGHT);
    end else begin
      r = HW'(v);
    end
    return r;
  endfunction

  fe_state_e                      st_q, st_d;
  logic [gcpd_pkg::THRESH_W-1:0]  thr_q, thr_d;
  logic [WW-1:0]                  w_q, w_d;
  logic [HW-1:0]                  h_q, h_d;
  logic [CW-1:0]                  in_col_q, in_col_d;
  logic [RW-1:0]                  in_row_q, in_row_d;
  logic [CW-1:0]                  out_col_q, out_col_d;
  logic [RW-1:0]                  out_row_q, out_row_d;
  logic [LW-1:0]                  p_q, p_d;
  logic [LW-1:0]                  q_q, q_d;
  logic [LW-1:0]                  total_q, total_d;
  logic                           done_q, done_d;

  logic                           accept;
  logic                           cfg_we;
  logic                           is_flush;
  logic                           col_wrap;
  logic [CW-1:0]                  ncol;
  logic [LW-1:0]                  row_inc;
  logic [RW-1:0]                  nrow;
  logic                           col_end;
  logic                           row_end;
  logic                           reach;
  logic                           last;
  logic                           border;
  logic                           ocol_end;
  logic                           pix_take;
  logic                           emit;
  logic [HW-1:0]                  mul_a;
  logic [CW-1:0]                  mul_add;
  logic [MW-1:0]                  prod;
  logic [LW-1:0]                  mac;

  // handshakes
  assign accept      = pix_i.valid && pix_i.ready;
  assign pix_i.ready = (st_q == ST_RUN) && !full_i;
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign threshold_o = thr_q;
  assign is_flush    = (pix_i.opcode == gcpd_pkg::OP_FLUSH);

  // input position, wrapped when the frame size shrank
  assign col_wrap = (LW'(in_col_q) >= LW'(w_q));
  assign ncol     = col_wrap ? '0 : in_col_q;
  assign row_inc  = col_wrap ? (LW'(in_row_q) + LW'(1)) : LW'(in_row_q);
  assign nrow     = (row_inc >= LW'(h_q)) ? '0 : RW'(row_inc);
  assign col_end  = (LW'(ncol) + LW'(1)) >= LW'(w_q);
  assign row_end  = (LW'(nrow) + LW'(1)) >= LW'(h_q);

  // result decision on the output position
  assign reach    = p_q >= (q_q + LW'(w_q) + LW'(1));
  assign last     = (q_q + LW'(1)) >= total_q;
  assign border   = (out_row_q == '0) || ((LW'(out_row_q) + LW'(1)) >= LW'(h_q)) ||
                    (out_col_q == '0) || ((LW'(out_col_q) + LW'(1)) >= LW'(w_q));
  assign ocol_end = (LW'(out_col_q) + LW'(1)) >= LW'(w_q);
  assign pix_take = accept && !is_flush && !done_q;
  assign emit     = accept && (is_flush ? done_q : (!done_q && reach));

  // shared multiply-add for index rebuild
  always_comb begin
    unique case (st_q)
      ST_MUL_P: begin
        mul_a   = HW'(nrow);
        mul_add = ncol;
      end
      ST_MUL_Q: begin
        mul_a   = HW'(out_row_q);
        mul_add = out_col_q;
      end
      default: begin
        mul_a   = h_q;
        mul_add = '0;
      end
    endcase
  end

  assign prod = MW'(mul_a) * MW'(w_q);
  assign mac  = LW'(prod) + LW'(mul_add);

  // item to the queue
  assign push_o      = pix_take || (accept && is_flush && done_q);
  assign item_o.is_pix = !is_flush;
  assign item_o.emit   = emit;
  assign item_o.zero   = is_flush || border;
  assign item_o.last   = last;
  assign item_o.pix    = pix_i.pixel_value;
  assign x_o           = ncol;

  // next state
  always_comb begin
    st_d      = st_q;
    thr_d     = thr_q;
    w_d       = w_q;
    h_d       = h_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    p_d       = p_q;
    q_d       = q_q;
    total_d   = total_q;
    done_d    = done_q;

    // input raster advance
    if (pix_take) begin
      in_col_d = col_end ? '0 : ncol + CW'(1);
      in_row_d = col_end ? (row_end ? '0 : nrow + RW'(1)) : nrow;
      p_d      = (col_end && row_end) ? '0 : p_q + LW'(1);
      if (col_end && row_end) begin
        done_d = 1'b1;
      end
    end

    // output raster advance
    if (emit) begin
      priority if (last) begin
        out_col_d = '0;
        out_row_d = '0;
        q_d       = '0;
        done_d    = 1'b0;
      end else if (ocol_end) begin
        out_col_d = '0;
        out_row_d = out_row_q + RW'(1);
        q_d       = q_q - LW'(out_col_q) + LW'(w_q);
      end else begin
        out_col_d = out_col_q + CW'(1);
        q_d       = q_q + LW'(1);
      end
    end

    // index rebuild sequence
    unique case (st_q)
      ST_RUN: begin
        st_d = ST_RUN;
      end
      ST_MUL_P: begin
        p_d  = mac;
        st_d = ST_MUL_Q;
      end
      ST_MUL_Q: begin
        q_d  = mac;
        st_d = ST_MUL_T;
      end
      ST_MUL_T: begin
        total_d = mac;
        st_d    = ST_RUN;
      end
      default: begin
        st_d = ST_MUL_P;
      end
    endcase

    // register writes restart the rebuild
    if (cfg_we) begin
      st_d = ST_MUL_P;
      unique case (cfg_i.index)
        gcpd_pkg::REG_THRESHOLD: thr_d = cfg_i.data[gcpd_pkg::THRESH_W-1:0];
        gcpd_pkg::REG_WIDTH:     w_d   = sat_width(cfg_i.data);
        gcpd_pkg::REG_HEIGHT:    h_d   = sat_height(cfg_i.data);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_MUL_P;
      thr_q     <= '0;
      w_q       <= sat_width(gcpd_pkg::DIM_RESET);
      h_q       <= sat_height(gcpd_pkg::DIM_RESET);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      p_q       <= '0;
      q_q       <= '0;
      total_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      st_q      <= st_d;
      thr_q     <= thr_d;
      w_q       <= w_d;
      h_q       <= h_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      p_q       <= p_d;
      q_q       <= q_d;
      total_q   <= total_d;
      done_q    <= done_d;
    end
  end

endmodule

// File: src/gcpd_back.sv
// back end: line store, 3x3 window, ring code match and result register
module gcpd_back #(
  parameter int unsigned MAX_WIDTH = gcpd_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [gcpd_pkg::THRESH_W-1:0]   threshold_i,
  input  logic                            q_valid_i,
  input  gcpd_pkg::item_t                 q_item_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]    q_x_i,
  output logic                            q_pop_o,
  gcpd_res_if.source                      res_o
);

  localparam int unsigned XW     = $clog2(MAX_WIDTH);
  localparam int unsigned PW     = gcpd_pkg::PIX_W;
  localparam int unsigned LINE_W = 2 * PW;

  // each entry holds the older row above the newer row
  logic [LINE_W-1:0]  line_mem [MAX_WIDTH];
  logic [LINE_W-1:0]  rd_q;
  logic [LINE_W-1:0]  byp_data_q;
  logic               byp_q;
  logic [LINE_W-1:0]  rd_eff;
  logic [PW-1:0]      rd_older;
  logic [PW-1:0]      rd_newer;
  logic [LINE_W-1:0]  wr_data;

  logic               adv;
  logic               take;
  logic               rd_en;
  logic               wr_en;

  logic               r_valid_q;
  gcpd_pkg::item_t    r_item_q;
  logic [XW-1:0]      r_x_q;
  logic               w_valid_q;
  gcpd_pkg::item_t    w_item_q;
  logic [PW-1:0]      window_q [9];
  logic [PW-1:0]      window_d [9];

  logic [PW-1:0]      diff [8];
  logic [7:0]         ring_code;
  logic [PW-1:0]      corner_d;

  logic               out_valid_q;
  logic [PW-1:0]      corner_q;
  logic               last_q;

  // pipeline moves whenever the result register can take a transfer
  assign adv     = !out_valid_q || res_o.ready;
  assign take    = adv && q_valid_i;
  assign q_pop_o = take;
  assign rd_en   = take && q_item_i.is_pix;
  assign wr_en   = adv && r_valid_q && r_item_q.is_pix;

  // line store data with forwarding of the write in flight
  assign rd_eff   = byp_q ? byp_data_q : rd_q;
  assign rd_older = rd_eff[LINE_W-1:PW];
  assign rd_newer = rd_eff[PW-1:0];
  assign wr_data  = {rd_newer, r_item_q.pix};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[r_x_q] <= wr_data;
    end
    if (rd_en) begin
      rd_q       <= line_mem[q_x_i];
      byp_data_q <= wr_data;
    end
  end

  // window shift by one column
  always_comb begin
    window_d[0] = window_q[1];
    window_d[1] = window_q[2];
    window_d[2] = rd_older;
    window_d[3] = window_q[4];
    window_d[4] = window_q[5];
    window_d[5] = rd_newer;
    window_d[6] = window_q[7];
    window_d[7] = window_q[8];
    window_d[8] = r_item_q.pix;
  end

  // similarity of each ring neighbour to the centre
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      diff[i] = (window_q[4] >= window_q[gcpd_pkg::RING_TAP[i]]) ?
                (window_q[4] - window_q[gcpd_pkg::RING_TAP[i]]) :
                (window_q[gcpd_pkg::RING_TAP[i]] - window_q[4]);
      ring_code[i] = (diff[i] <= threshold_i);
    end
  end

  assign corner_d = (w_item_q.zero || !gcpd_pkg::ring_match(ring_code)) ?
                    '0 : gcpd_pkg::CORNER_ON;

  // control and window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q   <= 1'b0;
      w_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      byp_q       <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        window_q[i] <= '0;
      end
    end else if (adv) begin
      r_valid_q   <= q_valid_i;
      w_valid_q   <= r_valid_q;
      out_valid_q <= w_valid_q && w_item_q.emit;
      if (rd_en) begin
        byp_q <= wr_en && (q_x_i == r_x_q);
      end
      if (wr_en) begin
        for (int i = 0; i < 9; i++) begin
          window_q[i] <= window_d[i];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_item_q <= q_item_i;
      r_x_q    <= q_x_i;
      w_item_q <= r_item_q;
      corner_q <= corner_d;
      last_q   <= w_item_q.last;
    end
  end

  // result channel
  assign res_o.valid         = out_valid_q;
  assign res_o.valid_res     = 1'b1;
  assign res_o.corner_value  = corner_q;
  assign res_o.last_of_frame = last_q;

endmodule
